@@ rtl/mmsr_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the multi-motor sine-ramp PWM block.
// No dependencies; imported by multi_motor_sine_ramp_pwm_top.
package mmsr_pkg;

    localparam int VEL_W      = 8;
    localparam int DUR_W      = 10;
    localparam int DIVR_W     = 8;
    localparam int PROG_W     = 12;
    localparam int IDX_W      = 7;
    localparam int ENTRY_W    = 17;
    localparam int DVD_W      = 19;   // width of 100 * progress
    localparam int DVS_W      = 10;   // width of the largest divisor (ramp time)
    localparam int DIV_CNT_W  = 5;
    localparam logic [PROG_W-1:0]  PROG_MAX    = 12'hFFF;
    localparam logic [IDX_W-1:0]   FULL_SCALE  = 7'd100;
    localparam logic [ENTRY_W-1:0] ENTRY_ONE   = 17'd65536;

    typedef enum logic [1:0] {
        PH_STOP   = 2'd0,
        PH_UP     = 2'd1,
        PH_STEADY = 2'd2,
        PH_DOWN   = 2'd3
    } phase_t;

    typedef enum logic [0:0] {
        MODE_TICK = 1'b0,
        MODE_MOVE = 1'b1
    } mode_t;

    typedef struct packed {
        mode_t              mode;
        logic [1:0]         motor_index;
        logic [VEL_W-1:0]   velocity;
        logic               direction;
        logic [DUR_W-1:0]   duration;
        logic [DIVR_W-1:0]  ramp_divisor;
    } cmd_t;

    typedef struct packed {
        logic [1:0]         served_motor;
        logic [VEL_W-1:0]   duty;
        logic               drive_direction;
        phase_t             phase;
    } result_t;

    // Quarter sine, round(65536 * sin(i * pi / 200)) for i = 0..100.
    localparam logic [ENTRY_W-1:0] SINE_Q16 [0:100] = '{
        17'd0, 17'd1029, 17'd2059, 17'd3087, 17'd4115, 17'd5142, 17'd6167, 17'd7192,
        17'd8214, 17'd9234, 17'd10252, 17'd11268, 17'd12280, 17'd13290, 17'd14296,
        17'd15299, 17'd16298, 17'd17293, 17'd18284, 17'd19270, 17'd20252, 17'd21228,
        17'd22200, 17'd23165, 17'd24125, 17'd25080, 17'd26027, 17'd26969, 17'd27904,
        17'd28832, 17'd29753, 17'd30666, 17'd31572, 17'd32470, 17'd33361, 17'd34242,
        17'd35116, 17'd35981, 17'd36837, 17'd37684, 17'd38521, 17'd39349, 17'd40167,
        17'd40976, 17'd41774, 17'd42562, 17'd43340, 17'd44107, 17'd44862, 17'd45607,
        17'd46341, 17'd47063, 17'd47774, 17'd48472, 17'd49159, 17'd49834, 17'd50496,
        17'd51146, 17'd51784, 17'd52408, 17'd53020, 17'd53618, 17'd54204, 17'd54775,
        17'd55334, 17'd55879, 17'd56410, 17'd56927, 17'd57430, 17'd57918, 17'd58393,
        17'd58853, 17'd59299, 17'd59730, 17'd60146, 17'd60547, 17'd60934, 17'd61305,
        17'd61662, 17'd62003, 17'd62328, 17'd62639, 17'd62934, 17'd63213, 17'd63477,
        17'd63725, 17'd63958, 17'd64174, 17'd64375, 17'd64560, 17'd64729, 17'd64882,
        17'd65019, 17'd65140, 17'd65245, 17'd65334, 17'd65407, 17'd65463, 17'd65504,
        17'd65528, 17'd65536
    };

endpackage

@@ rtl/multi_motor_sine_ramp_pwm_top.sv @@
`timescale 1ns / 1ps
// Multi-motor sine-ramped PWM velocity profile generator, top level.
// Depends on mmsr_pkg (types, sine table, widths).
//
// Usage: present an item on command with start high; it is taken on a clock
// edge where busy is low. A move item (mode 1) loads one motor slot and gives
// no result; its work is a load, 19 divider steps for duration / ramp_divisor
// and a store. A tick item (mode 0) only advances the prescaler, except on
// every (TICK_DIVIDE+1)-th tick, when the next motor in round-robin order is
// served: that item does a slot read and progress update, 19 steps of the
// shared restoring divider for 100 * ramp progress / ramp_time, a sine
// table lookup and one 8x17 multiply, and ends with one result. The result
// is shown on result for exactly one cycle with result_strobe high; the
// receiver cannot stall it, so capture it then.
// busy stays high for the whole of an item's work. Motor slots at or above
// NUM_MOTORS ignore move items; slots beyond the fourth cannot be addressed
// by the two-bit motor_index and so stay stopped.
module multi_motor_sine_ramp_pwm_top #(
    parameter int NUM_MOTORS  = 4,
    parameter int TICK_DIVIDE = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  mmsr_pkg::cmd_t    command,
    output logic              busy,
    output mmsr_pkg::result_t result,
    output logic              result_strobe
);
    import mmsr_pkg::*;

    localparam int PTR_W = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;
    localparam int PS_W  = $clog2(TICK_DIVIDE + 1);
    localparam logic [PTR_W-1:0]  PTR_LAST  = PTR_W'(NUM_MOTORS - 1);
    localparam logic [PS_W-1:0]   PS_LAST   = PS_W'(TICK_DIVIDE);
    localparam logic [PROG_W:0]   STEP_RAMP = (PROG_W + 1)'(TICK_DIVIDE);
    localparam logic [PROG_W:0]   STEP_FAST = (PROG_W + 1)'(2 * TICK_DIVIDE);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DVD_W - 1);

    // Sequencer: one-hot states.
    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_LOAD   = 6'b000010,   // read slot, advance progress, form dividend
        ST_DIV    = 6'b000100,   // one restoring division step per cycle
        ST_LOOKUP = 6'b001000,   // sine index and table entry
        ST_FIN    = 6'b010000,   // duty multiply, present result
        ST_STORE  = 6'b100000    // write a move item into its slot
    } state_t;

    function automatic logic [DVD_W-1:0] times_100(input logic [PROG_W-1:0] x);
        logic [DVD_W-1:0] xe;
        xe = DVD_W'(x);
        return (xe << 6) + (xe << 5) + (xe << 2);
    endfunction

    // Per-slot profile state.
    phase_t            phase_reg     [NUM_MOTORS];
    logic [VEL_W-1:0]  peak_vel_reg  [NUM_MOTORS];
    logic [PROG_W-1:0] progress_reg  [NUM_MOTORS];
    logic [DUR_W-1:0]  ramp_reg      [NUM_MOTORS];
    logic [DUR_W-1:0]  steady_end_reg[NUM_MOTORS];
    logic [DUR_W-1:0]  move_end_reg  [NUM_MOTORS];
    logic              dir_reg       [NUM_MOTORS];

    state_t              state_reg, state_next;
    logic [PS_W-1:0]     prescale_reg, prescale_next;
    logic [PTR_W-1:0]    pointer_reg, pointer_next;
    logic [PTR_W-1:0]    slot_reg, slot_next;
    logic                is_move_reg, is_move_next;
    logic [VEL_W-1:0]    w_vel_reg, w_vel_next;
    logic                w_dir_reg, w_dir_next;
    logic [DUR_W-1:0]    w_dur_reg, w_dur_next;
    phase_t              w_phase_reg, w_phase_next;
    logic                ramp_zero_reg, ramp_zero_next;
    logic [DVS_W-1:0]    rem_reg, rem_next;
    logic [DVD_W-1:0]    quot_reg, quot_next;
    logic [DVS_W-1:0]    divisor_reg, divisor_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic [ENTRY_W-1:0]  entry_reg, entry_next;
    result_t             result_reg, result_next;
    logic                strobe_reg, strobe_next;

    // Slot write port.
    logic              slot_upd;       // progress / phase update of a served slot
    logic              slot_load;      // full load from a move item
    phase_t            upd_phase;
    logic [PROG_W-1:0] upd_prog;

    // LOAD datapath.
    phase_t            cur_phase;
    logic [PROG_W-1:0] cur_prog;
    logic [DUR_W-1:0]  cur_ramp;
    logic [DUR_W-1:0]  cur_steady;
    logic [DUR_W-1:0]  cur_move;
    logic [PROG_W:0]   prog_sum;
    logic [PROG_W-1:0] prog_adv;
    logic [PROG_W-1:0] down_diff;
    logic [DVD_W-1:0]  dividend;

    // Divider step.
    logic [DVS_W:0]    shifted;
    logic              step_ge;

    // Lookup / multiply.
    logic [IDX_W-1:0]  sine_idx;
    logic [VEL_W+ENTRY_W-1:0] product;
    logic [DIVR_W-1:0] divr_fixed;

    assign cur_phase  = phase_reg[slot_reg];
    assign cur_prog   = progress_reg[slot_reg];
    assign cur_ramp   = ramp_reg[slot_reg];
    assign cur_steady = steady_end_reg[slot_reg];
    assign cur_move   = move_end_reg[slot_reg];

    // Advance progress: steady runs twice as fast; saturate at full count.
    always_comb
    begin
        prog_sum  = {1'b0, cur_prog} + ((cur_phase == PH_STEADY) ? STEP_FAST : STEP_RAMP);
        prog_adv  = (prog_sum > {1'b0, PROG_MAX}) ? PROG_MAX : prog_sum[PROG_W-1:0];
        down_diff = (cur_prog > PROG_W'(cur_steady)) ? cur_prog - PROG_W'(cur_steady)
                                                      : '0;
        upd_phase = cur_phase;
        upd_prog  = prog_adv;
        dividend  = '0;
        unique case (cur_phase)
            PH_UP:
            begin
                dividend = times_100(cur_prog);
                if (prog_adv >= PROG_W'(cur_ramp))
                    upd_phase = PH_STEADY;
            end
            PH_STEADY:
            begin
                if (prog_adv >= PROG_W'(cur_steady))
                    upd_phase = PH_DOWN;
            end
            PH_DOWN:
            begin
                dividend = times_100(down_diff);
                if (prog_adv >= PROG_W'(cur_move))
                    upd_phase = PH_STOP;
            end
            PH_STOP:
            begin
                upd_prog = '0;
            end
        endcase
    end

    // One restoring division step.
    assign shifted = {rem_reg, quot_reg[DVD_W-1]};
    assign step_ge = (shifted >= {1'b0, divisor_reg});

    // Ramp-up index clamps at full scale; ramp-down index floors at zero.
    always_comb
    begin
        sine_idx = '0;
        unique case (w_phase_reg)
            PH_UP:
                sine_idx = (quot_reg > DVD_W'(FULL_SCALE)) ? FULL_SCALE
                                                           : quot_reg[IDX_W-1:0];
            PH_DOWN:
                sine_idx = (quot_reg >= DVD_W'(FULL_SCALE)) ? '0
                                                            : FULL_SCALE - quot_reg[IDX_W-1:0];
            PH_STEADY,
            PH_STOP:
                sine_idx = '0;
        endcase
    end

    assign product    = (VEL_W + ENTRY_W)'(w_vel_reg) * (VEL_W + ENTRY_W)'(entry_reg);
    assign divr_fixed = (command.ramp_divisor == '0) ? DIVR_W'(1) : command.ramp_divisor;

    always_comb
    begin
        state_next     = state_reg;
        prescale_next  = prescale_reg;
        pointer_next   = pointer_reg;
        slot_next      = slot_reg;
        is_move_next   = is_move_reg;
        w_vel_next     = w_vel_reg;
        w_dir_next     = w_dir_reg;
        w_dur_next     = w_dur_reg;
        w_phase_next   = w_phase_reg;
        ramp_zero_next = ramp_zero_reg;
        rem_next       = rem_reg;
        quot_next      = quot_reg;
        divisor_next   = divisor_reg;
        div_cnt_next   = div_cnt_reg;
        entry_next     = entry_reg;
        result_next    = result_reg;
        strobe_next    = 1'b0;
        slot_upd       = 1'b0;
        slot_load      = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (command.mode == MODE_MOVE)
                    begin
                        // Drop moves to slots that do not exist.
                        if (int'(command.motor_index) < NUM_MOTORS)
                        begin
                            slot_next    = PTR_W'(command.motor_index);
                            is_move_next = 1'b1;
                            w_vel_next   = command.velocity;
                            w_dir_next   = command.direction;
                            w_dur_next   = command.duration;
                            rem_next     = '0;
                            quot_next    = DVD_W'(command.duration);
                            divisor_next = DVS_W'(divr_fixed);
                            div_cnt_next = DIV_LAST;
                            state_next   = ST_DIV;
                        end
                    end
                    else if (prescale_reg < PS_LAST)
                    begin
                        prescale_next = prescale_reg + PS_W'(1);
                    end
                    else
                    begin
                        prescale_next = '0;
                        slot_next     = pointer_reg;
                        pointer_next  = (pointer_reg == PTR_LAST) ? '0
                                                                  : pointer_reg + PTR_W'(1);
                        is_move_next  = 1'b0;
                        state_next    = ST_LOAD;
                    end
                end
            end
            ST_LOAD:
            begin
                slot_upd       = 1'b1;
                w_phase_next   = cur_phase;
                w_vel_next     = peak_vel_reg[slot_reg];
                w_dir_next     = dir_reg[slot_reg];
                ramp_zero_next = (cur_ramp == '0);
                rem_next       = '0;
                quot_next      = dividend;
                divisor_next   = cur_ramp;
                div_cnt_next   = DIV_LAST;
                state_next     = ST_DIV;
            end
            ST_DIV:
            begin
                rem_next     = step_ge ? DVS_W'(shifted - {1'b0, divisor_reg})
                                       : shifted[DVS_W-1:0];
                quot_next    = {quot_reg[DVD_W-2:0], step_ge};
                div_cnt_next = div_cnt_reg - DIV_CNT_W'(1);
                if (div_cnt_reg == '0)
                    state_next = is_move_reg ? ST_STORE : ST_LOOKUP;
            end
            ST_LOOKUP:
            begin
                // Steady and zero-length ramps run at full velocity; stop gives zero.
                priority if (w_phase_reg == PH_STOP)
                    entry_next = '0;
                else if (w_phase_reg == PH_STEADY || ramp_zero_reg)
                    entry_next = ENTRY_ONE;
                else
                    entry_next = SINE_Q16[sine_idx];
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                result_next.served_motor    = 2'(slot_reg);
                result_next.duty            = product[ENTRY_W+VEL_W-2:ENTRY_W-1];
                result_next.drive_direction = w_dir_reg;
                result_next.phase           = w_phase_reg;
                strobe_next                 = 1'b1;
                state_next                  = ST_IDLE;
            end
            ST_STORE:
            begin
                slot_load  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            prescale_reg <= '0;
            pointer_reg  <= '0;
            strobe_reg   <= 1'b0;
            slot_reg     <= '0;
            w_phase_reg  <= PH_STOP;
            for (int i = 0; i < NUM_MOTORS; i++)
            begin
                phase_reg[i]      <= PH_STOP;
                peak_vel_reg[i]   <= '0;
                progress_reg[i]   <= '0;
                ramp_reg[i]       <= '0;
                steady_end_reg[i] <= '0;
                move_end_reg[i]   <= '0;
                dir_reg[i]        <= 1'b0;
            end
        end
        else
        begin
            state_reg    <= state_next;
            prescale_reg <= prescale_next;
            pointer_reg  <= pointer_next;
            strobe_reg   <= strobe_next;
            slot_reg     <= slot_next;
            w_phase_reg  <= w_phase_next;
            if (slot_upd)
            begin
                phase_reg[slot_reg]    <= upd_phase;
                progress_reg[slot_reg] <= upd_prog;
            end
            else if (slot_load)
            begin
                // Ramp time is the quotient; steady ends one ramp before the end.
                phase_reg[slot_reg]      <= PH_UP;
                progress_reg[slot_reg]   <= '0;
                peak_vel_reg[slot_reg]   <= w_vel_reg;
                dir_reg[slot_reg]        <= w_dir_reg;
                ramp_reg[slot_reg]       <= quot_reg[DUR_W-1:0];
                steady_end_reg[slot_reg] <= w_dur_reg - quot_reg[DUR_W-1:0];
                move_end_reg[slot_reg]   <= w_dur_reg;
            end
        end
    end

    // Datapath registers: no reset needed.
    always_ff @(posedge clk)
    begin
        is_move_reg   <= is_move_next;
        w_vel_reg     <= w_vel_next;
        w_dir_reg     <= w_dir_next;
        w_dur_reg     <= w_dur_next;
        ramp_zero_reg <= ramp_zero_next;
        rem_reg       <= rem_next;
        quot_reg      <= quot_next;
        divisor_reg   <= divisor_next;
        div_cnt_reg   <= div_cnt_next;
        entry_reg     <= entry_next;
        result_reg    <= result_next;
    end

    assign busy          = (state_reg != ST_IDLE);
    assign result        = result_reg;
    assign result_strobe = strobe_reg;

endmodule
